### hdl/mle_pkg.sv
package mle_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int TIME_W = 16;
    localparam int CHAR_W = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int SEG_W = 4;

    localparam logic [CHAR_W-1:0] ASCII_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_Z = 8'h5A;

    localparam logic [CFG_INDEX_W-1:0] CFG_DOT_ON = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DASH_ON = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_GAP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LETTER_GAP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNKNOWN_GAP = 3'd4;

    localparam logic [TIME_W-1:0] DOT_ON_RESET = 16'd200;
    localparam logic [TIME_W-1:0] DASH_ON_RESET = 16'd600;
    localparam logic [TIME_W-1:0] ELEMENT_GAP_RESET = 16'd200;
    localparam logic [TIME_W-1:0] LETTER_GAP_RESET = 16'd1000;
    localparam logic [TIME_W-1:0] UNKNOWN_GAP_RESET = 16'd1000;

    // Bit i of dashes is element i of the letter, 1 for a dash.
    typedef struct packed {
        logic       known;
        logic [2:0] len;
        logic [3:0] dashes;
    } entry_t;

    function automatic entry_t morse_lookup(input logic [4:0] idx);
        entry_t e;
        e.known = 1'b1;
        case (idx)
            5'd0:    begin e.len = 3'd2; e.dashes = 4'b0010; end
            5'd1:    begin e.len = 3'd4; e.dashes = 4'b0001; end
            5'd2:    begin e.len = 3'd4; e.dashes = 4'b0101; end
            5'd3:    begin e.len = 3'd3; e.dashes = 4'b0001; end
            5'd4:    begin e.len = 3'd1; e.dashes = 4'b0000; end
            5'd5:    begin e.len = 3'd4; e.dashes = 4'b0100; end
            5'd6:    begin e.len = 3'd3; e.dashes = 4'b0011; end
            5'd7:    begin e.len = 3'd4; e.dashes = 4'b0000; end
            5'd8:    begin e.len = 3'd2; e.dashes = 4'b0000; end
            5'd9:    begin e.len = 3'd4; e.dashes = 4'b1110; end
            5'd10:   begin e.len = 3'd3; e.dashes = 4'b0101; end
            5'd11:   begin e.len = 3'd4; e.dashes = 4'b0010; end
            5'd12:   begin e.len = 3'd2; e.dashes = 4'b0011; end
            5'd13:   begin e.len = 3'd2; e.dashes = 4'b0001; end
            5'd14:   begin e.len = 3'd3; e.dashes = 4'b0111; end
            5'd15:   begin e.len = 3'd4; e.dashes = 4'b0110; end
            5'd16:   begin e.len = 3'd4; e.dashes = 4'b1011; end
            5'd17:   begin e.len = 3'd3; e.dashes = 4'b0010; end
            5'd18:   begin e.len = 3'd3; e.dashes = 4'b0000; end
            5'd19:   begin e.len = 3'd1; e.dashes = 4'b0001; end
            5'd20:   begin e.len = 3'd3; e.dashes = 4'b0100; end
            5'd21:   begin e.len = 3'd4; e.dashes = 4'b1000; end
            5'd22:   begin e.len = 3'd3; e.dashes = 4'b0110; end
            5'd23:   begin e.len = 3'd4; e.dashes = 4'b1001; end
            5'd24:   begin e.len = 3'd4; e.dashes = 4'b1101; end
            5'd25:   begin e.len = 3'd4; e.dashes = 4'b0011; end
            default: begin e.known = 1'b0; e.len = 3'd0; e.dashes = 4'b0000; end
        endcase
        return e;
    endfunction

endpackage

### hdl/mle_front.sv
module mle_front (
    input  logic                            start,
    input  logic [mle_pkg::CHAR_W-1:0]      character,
    input  logic                            full,
    output logic                            push,
    output mle_pkg::entry_t                 entry
);

    logic                       is_letter;
    logic [mle_pkg::CHAR_W-1:0] offset;

    assign push = start && !full;
    assign is_letter = (character >= mle_pkg::ASCII_A) && (character <= mle_pkg::ASCII_Z);
    assign offset = character - mle_pkg::ASCII_A;

    always_comb
    begin
        if (is_letter)
        begin
            entry = mle_pkg::morse_lookup(offset[4:0]);
        end
        else
        begin
            entry.known = 1'b0;
            entry.len = 3'd0;
            entry.dashes = 4'b0000;
        end
    end

endmodule

### hdl/mle_queue.sv
module mle_queue #(
    parameter int DEPTH = mle_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mle_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output mle_pkg::entry_t head_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mle_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hdl/mle_back.sv
module mle_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mle_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mle_pkg::TIME_W-1:0]         cfg_data,
    input  logic                               head_valid,
    input  mle_pkg::entry_t                    head_entry,
    output logic                               pop,
    output logic                               strobe,
    output logic                               led_on,
    output logic [mle_pkg::TIME_W-1:0]         duration,
    output logic                               last_segment
);

    logic [mle_pkg::TIME_W-1:0] dot_on_reg;
    logic [mle_pkg::TIME_W-1:0] dash_on_reg;
    logic [mle_pkg::TIME_W-1:0] element_gap_reg;
    logic [mle_pkg::TIME_W-1:0] letter_gap_reg;
    logic [mle_pkg::TIME_W-1:0] unknown_gap_reg;

    logic                      active_reg;
    mle_pkg::entry_t           cur_reg;
    logic [mle_pkg::SEG_W-1:0] seg_reg;
    logic                      strobe_reg;
    logic                      led_on_reg;
    logic [mle_pkg::TIME_W-1:0] duration_reg;
    logic                      last_reg;

    logic [mle_pkg::SEG_W-1:0] last_idx;
    logic                      finishing;
    logic                      led_on_next;
    logic [mle_pkg::TIME_W-1:0] duration_next;
    logic                      last_next;

    assign last_idx = cur_reg.known ? {cur_reg.len, 1'b0} : mle_pkg::SEG_W'(1);
    assign finishing = active_reg && (seg_reg == last_idx);
    assign pop = head_valid && (!active_reg || finishing);

    always_comb
    begin
        led_on_next = 1'b0;
        last_next = 1'b0;
        if (seg_reg == last_idx)
        begin
            duration_next = letter_gap_reg;
            last_next = 1'b1;
        end
        else if (!cur_reg.known)
        begin
            duration_next = unknown_gap_reg;
        end
        else if (!seg_reg[0])
        begin
            led_on_next = 1'b1;
            duration_next = cur_reg.dashes[seg_reg[2:1]] ? dash_on_reg : dot_on_reg;
        end
        else
        begin
            duration_next = element_gap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_on_reg <= mle_pkg::DOT_ON_RESET;
            dash_on_reg <= mle_pkg::DASH_ON_RESET;
            element_gap_reg <= mle_pkg::ELEMENT_GAP_RESET;
            letter_gap_reg <= mle_pkg::LETTER_GAP_RESET;
            unknown_gap_reg <= mle_pkg::UNKNOWN_GAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mle_pkg::CFG_DOT_ON:      dot_on_reg <= cfg_data;
                mle_pkg::CFG_DASH_ON:     dash_on_reg <= cfg_data;
                mle_pkg::CFG_ELEMENT_GAP: element_gap_reg <= cfg_data;
                mle_pkg::CFG_LETTER_GAP:  letter_gap_reg <= cfg_data;
                mle_pkg::CFG_UNKNOWN_GAP: unknown_gap_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cur_reg <= '0;
            seg_reg <= '0;
            strobe_reg <= 1'b0;
            led_on_reg <= 1'b0;
            duration_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            led_on_reg <= led_on_next;
            duration_reg <= duration_next;
            last_reg <= last_next;
            if (pop)
            begin
                active_reg <= 1'b1;
                cur_reg <= head_entry;
                seg_reg <= '0;
            end
            else if (finishing)
            begin
                active_reg <= 1'b0;
            end
            else if (active_reg)
            begin
                seg_reg <= seg_reg + 1'b1;
            end
        end
    end

    assign strobe = strobe_reg;
    assign led_on = led_on_reg;
    assign duration = duration_reg;
    assign last_segment = last_reg;

`ifndef NO_ASSERTIONS
    a_last_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |-> !led_on_reg)
        else $error("Letter gap segment is not dark.");

    a_on_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && led_on_reg |=> strobe_reg && !led_on_reg && !last_reg)
        else $error("Lit segment not followed by an element gap.");

    a_active_emits: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !finishing |=> active_reg && strobe_reg)
        else $error("Character stopped before its letter gap.");
`endif

endmodule

### hdl/morse_letter_encoder_top.sv
// Channel   Direction  Transfer rule              Signals
// input     in         start && !busy at edge     character
// result    out        strobe, one cycle each     led_on, duration, last_segment
// config    in         cfg_wr_en at edge          cfg_index, cfg_data
//
// The back sequencer gives one segment per cycle, 2 to 9 segments per character.
// A character waits in the queue, then in the sequencer's character register, then leaves via the output registers.
// busy is high while the character queue of QUEUE_DEPTH entries is full.
// Reset restores the timing registers to their defaults and empties the queue.
// The receiver cannot stall, so results never wait.
module morse_letter_encoder_top #(
    parameter int QUEUE_DEPTH = mle_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mle_pkg::CHAR_W-1:0]         character,
    output logic                               strobe,
    output logic                               led_on,
    output logic [mle_pkg::TIME_W-1:0]         duration,
    output logic                               last_segment,
    input  logic                               cfg_wr_en,
    input  logic [mle_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mle_pkg::TIME_W-1:0]         cfg_data
);

    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    mle_pkg::entry_t push_entry;
    mle_pkg::entry_t head_entry;

    assign busy = full;

    mle_front u_front (
        .start     (start),
        .character (character),
        .full      (full),
        .push      (push),
        .entry     (push_entry)
    );

    mle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    mle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .strobe       (strobe),
        .led_on       (led_on),
        .duration     (duration),
        .last_segment (last_segment)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [mle_pkg::CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [mle_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LAST = 3'd7;
    localparam logic [mle_pkg::TIME_W-1:0] TIME_MAX = 16'hFFFF;
    localparam byte DASH_MARK = "-";
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic                       led;
        logic [mle_pkg::TIME_W-1:0] dur;
        logic                       last;
    } segment_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [mle_pkg::CHAR_W-1:0]      character;
    logic                            strobe;
    logic                            led_on;
    logic [mle_pkg::TIME_W-1:0]      duration;
    logic                            last_segment;
    logic                            cfg_wr_en;
    logic [mle_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mle_pkg::TIME_W-1:0]      cfg_data;

    logic [mle_pkg::TIME_W-1:0] dot_ms = mle_pkg::DOT_ON_RESET;
    logic [mle_pkg::TIME_W-1:0] dash_ms = mle_pkg::DASH_ON_RESET;
    logic [mle_pkg::TIME_W-1:0] element_gap_ms = mle_pkg::ELEMENT_GAP_RESET;
    logic [mle_pkg::TIME_W-1:0] letter_gap_ms = mle_pkg::LETTER_GAP_RESET;
    logic [mle_pkg::TIME_W-1:0] unknown_gap_ms = mle_pkg::UNKNOWN_GAP_RESET;

    segment_t pending_segments[$];
    int       fail_count = 0;
    int       letters_sent = 0;
    int       others_sent = 0;
    int       segments_checked = 0;
    int       settings_used = 0;
    bit       steady_sender = 0;

    morse_letter_encoder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .character    (character),
        .strobe       (strobe),
        .led_on       (led_on),
        .duration     (duration),
        .last_segment (last_segment),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[morse_letter_encoder_top] ERROR");
        $finish;
    end

    function automatic string morse_code(input int unsigned idx);
        case (idx)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            default: return "--..";
        endcase
    endfunction

    task automatic predict_segments(input logic [mle_pkg::CHAR_W-1:0] ch);
        string code;
        int    i;
        if (ch >= mle_pkg::ASCII_A && ch <= mle_pkg::ASCII_Z)
        begin
            code = morse_code(ch - mle_pkg::ASCII_A);
            for (i = 0; i < code.len(); i++)
            begin
                pending_segments.push_back({1'b1,
                    (code[i] == DASH_MARK) ? dash_ms : dot_ms, 1'b0});
                pending_segments.push_back({1'b0, element_gap_ms, 1'b0});
            end
            letters_sent++;
        end
        else
        begin
            pending_segments.push_back({1'b0, unknown_gap_ms, 1'b0});
            others_sent++;
        end
        pending_segments.push_back({1'b0, letter_gap_ms, 1'b1});
    endtask

    // Results are checked, and transfers and register writes are mirrored,
    // on the values present at each rising edge.
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (pending_segments.size() == 0)
                begin
                    $error("segment with none expected: led_on=%0b duration=%0d last=%0b",
                           led_on, duration, last_segment);
                    fail_count++;
                end
                else
                begin
                    want = pending_segments.pop_front();
                    segments_checked++;
                    if (led_on !== want.led)
                    begin
                        $error("led_on: expected %0b, got %0b", want.led, led_on);
                        fail_count++;
                    end
                    if (duration !== want.dur)
                    begin
                        $error("duration: expected %0d, got %0d", want.dur, duration);
                        fail_count++;
                    end
                    if (last_segment !== want.last)
                    begin
                        $error("last_segment: expected %0b, got %0b", want.last,
                               last_segment);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    mle_pkg::CFG_DOT_ON:      dot_ms = cfg_data;
                    mle_pkg::CFG_DASH_ON:     dash_ms = cfg_data;
                    mle_pkg::CFG_ELEMENT_GAP: element_gap_ms = cfg_data;
                    mle_pkg::CFG_LETTER_GAP:  letter_gap_ms = cfg_data;
                    mle_pkg::CFG_UNKNOWN_GAP: unknown_gap_ms = cfg_data;
                    default:                  ;
                endcase
            end
            if (start && !busy)
                predict_segments(character);
        end
    end

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_char(input logic [mle_pkg::CHAR_W-1:0] ch);
        start <= 1'b1;
        character <= ch;
        do @(posedge clk); while (busy);
        if (!steady_sender && $urandom_range(99) < 15)
            pause_sender($urandom_range(1, 9));
    endtask

    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_char(text[i]);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_segments.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mle_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mle_pkg::TIME_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_timing(input logic [mle_pkg::TIME_W-1:0] dot, dash,
                                  element_gap, letter_gap, unknown_gap);
        write_reg(mle_pkg::CFG_DOT_ON, dot);
        write_reg(mle_pkg::CFG_DASH_ON, dash);
        write_reg(mle_pkg::CFG_ELEMENT_GAP, element_gap);
        write_reg(mle_pkg::CFG_LETTER_GAP, letter_gap);
        write_reg(mle_pkg::CFG_UNKNOWN_GAP, unknown_gap);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic logic [mle_pkg::TIME_W-1:0] random_time();
        case ($urandom_range(3))
            0:       return '0;
            1:       return TIME_MAX;
            default: return mle_pkg::TIME_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [mle_pkg::CHAR_W-1:0] random_char();
        if ($urandom_range(99) < 75)
            return mle_pkg::ASCII_A + mle_pkg::CHAR_W'($urandom_range(25));
        return mle_pkg::CHAR_W'($urandom_range(255));
    endfunction

    task automatic test_reset_defaults();
        send_text("ETBO");
        drain_results();
        settings_used++;
    endtask

    task automatic test_letters_and_bytes();
        send_text("AZQJYHM");
        send_char(8'h00);
        send_char(8'h20);
        send_char(8'h40);
        send_char(8'h5B);
        send_char(8'h61);
        send_char(8'h80);
        send_char(8'hFF);
        drain_results();
    endtask

    task automatic test_zero_durations();
        program_timing('0, '0, '0, '0, '0);
        send_text("HY0");
        drain_results();
    endtask

    task automatic test_full_durations();
        program_timing(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
        send_text("JQ");
        send_char(8'hFF);
        drain_results();
    endtask

    task automatic test_ignored_index();
        program_timing(16'd3, 16'd7, 16'd11, 16'd13, 16'd17);
        write_reg(CFG_SPARE_FIRST, 16'h5555);
        write_reg(CFG_SPARE_LAST, 16'hAAAA);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        send_text("A ");
        drain_results();
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++)
        begin
            program_timing(random_time(), random_time(), random_time(),
                           random_time(), random_time());
            steady_sender = (phase == 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_char(random_char());
                // Hold the sender until every outstanding transfer has completed.
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
            end
            drain_results();
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        character = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_letters_and_bytes();
        test_zero_durations();
        test_full_durations();
        test_ignored_index();
        test_random_traffic();

        $display("Sent %0d letters and %0d other bytes under %0d timing settings.",
                 letters_sent, others_sent, settings_used);
        $display("Checked %0d segments, including zero and full-scale durations.",
                 segments_checked);
        if (fail_count == 0)
            $display("[morse_letter_encoder_top] OK");
        else
            $display("[morse_letter_encoder_top] ERROR");
        $finish;
    end

endmodule
